FILE: rtl/core/bpa_pkg.sv
// Shared types, constants and a helper function of the bitmap page allocator.
`default_nettype none

package bpa_pkg;

  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 32;
  localparam int COUNT_W  = 17;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [COUNT_W-1:0]  count_t;

  localparam action_t ACT_RELEASE  = 2'd0;
  localparam action_t ACT_RESERVE  = 2'd1;
  localparam action_t ACT_ALLOCATE = 2'd2;
  localparam action_t ACT_NOP      = 2'd3;

  // Index of the lowest set bit of a 32-bit word; zero when the word is zero.
  function automatic logic [4:0] lowest_set(input logic [31:0] vec);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (vec[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bpa_req_if.sv
// Request channel of the bitmap page allocator: action and page address.
`default_nettype none

interface bpa_req_if
  import bpa_pkg::*;
;
  logic    valid;
  logic    ready;
  action_t action;
  addr_t   page_address;

  modport source(output valid, action, page_address, input ready);
  modport sink(input valid, action, page_address, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bpa_rsp_if.sv
// Response channel of the bitmap page allocator: grant, address and free count.
`default_nettype none

interface bpa_rsp_if
  import bpa_pkg::*;
;
  logic   valid;
  logic   ready;
  logic   granted;
  addr_t  alloc_address;
  count_t free_count;

  modport source(output valid, granted, alloc_address, free_count, input ready);
  modport sink(input valid, granted, alloc_address, free_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bitmap_page_allocator.sv
// Bitmap physical page allocator with a first-fit search helped by summary bits.
`default_nettype none

// The allocator keeps one used bit per physical page in a bitmap memory of
// 32-bit words, and answers every request transaction with exactly one response
// transaction. A release clears the page's bit, a reserve sets it, and an
// allocate finds the lowest free page, marks it used and returns its byte
// address. A second memory holds one summary bit per bitmap word (set when the
// word still has a free page), and a row of flip-flops holds one flag per
// summary word, so the first-fit search looks at 32 flags per cycle and then
// reads just one summary word and one bitmap word. A release or reserve runs
// from acceptance through the request step with its memory read, read-data
// capture and write-back; an allocate runs through the request step, the scan
// of the flag groups (at most ceil(2^SUM_AW / 32) of them, 2 at the default
// size), the summary read, the bitmap read and write-back. A release or
// reserve with a page number of NUM_PAGES or more, and a request with the spare
// action code, answer granted = 0 without changing memory; a failed allocate
// scans every flag group and answers granted = 0. After reset the block runs
// a clearing pass over all NUM_WORDS bitmap words (2048 at the default size)
// that marks every page used; no request is accepted during that pass.
// The free count moves only when a bit really flips. The response sits in an
// output register, so a new request is taken while a finished response still
// waits.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES  = 65536,
  parameter int PAGE_SHIFT = 12
) (
  input  wire        clk,
  input  wire        rst,
  bpa_req_if.sink    req,
  bpa_rsp_if.source  rsp
);

  localparam int NUM_WORDS = (NUM_PAGES + 31) / 32;
  localparam int NUM_SUM   = (NUM_WORDS + 31) / 32;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SUM_AW    = (NUM_SUM > 1) ? $clog2(NUM_SUM) : 1;
  localparam int NUM_CHUNK = ((1 << SUM_AW) + 31) / 32;
  localparam int CHUNK_AW  = (NUM_CHUNK > 1) ? $clog2(NUM_CHUNK) : 1;
  localparam int FLAG_N    = NUM_CHUNK * 32;
  localparam int CNT_W     = $clog2(NUM_PAGES + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SUMRD = 3'd4;
  localparam logic [2:0] S_WRD   = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // Bitmap memory (bit set = page used) and summary memory (bit set = the
  // bitmap word has a free page).
  logic [31:0] bm_mem [NUM_WORDS];
  logic [31:0] sm_mem [NUM_SUM];

  logic [2:0]          state;
  logic [WORD_AW-1:0]  clr_idx;
  logic [FLAG_N-1:0]   flags;
  logic [CNT_W-1:0]    cnt;
  logic [CHUNK_AW-1:0] chunk;
  action_t             act;
  logic [WORD_AW-1:0]  word_addr;
  logic [SUM_AW-1:0]   sum_addr;
  logic [4:0]          bit_idx;
  logic [31:0]         word_q;
  logic [31:0]         sum_q;

  logic                out_valid;
  logic                out_granted;
  addr_t               out_address;
  count_t              out_count;

  // Memory ports.
  logic               bm_we;
  logic [WORD_AW-1:0] bm_waddr;
  logic [31:0]        bm_wdata;
  logic [WORD_AW-1:0] bm_raddr;
  logic [31:0]        bm_rdata;
  logic               sm_we;
  logic [SUM_AW-1:0]  sm_waddr;
  logic [31:0]        sm_wdata;
  logic [SUM_AW-1:0]  sm_raddr;
  logic [31:0]        sm_rdata;

  // Request decode.
  logic [31:0]        req_page32;
  logic               req_in_range;
  logic [WORD_AW-1:0] req_word;
  logic [SUM_AW-1:0]  req_sum;

  // Search path.
  logic [31:0]        chunk_bits;
  logic [31:0]        scan32;
  logic [SUM_AW-1:0]  scan_sum;
  logic [31:0]        found32;
  logic [WORD_AW-1:0] found_word;

  // Update path.
  logic               slot_free;
  logic               set_op;
  logic               changed;
  logic [31:0]        bit_mask;
  logic [31:0]        new_word;
  logic [31:0]        word32;
  logic [31:0]        new_sum;
  logic [CNT_W-1:0]   cnt_next;
  logic [31:0]        page32;
  logic [31:0]        clr32;

  assign req.ready = (state == S_IDLE);
  assign slot_free = !out_valid || rsp.ready;

  assign req_page32   = req.page_address >> PAGE_SHIFT;
  assign req_in_range = req_page32 < 32'(NUM_PAGES);
  assign req_word     = req_page32[5 +: WORD_AW];
  assign req_sum      = req_page32[10 +: SUM_AW];

  assign chunk_bits = flags[{chunk, 5'd0} +: 32];
  assign scan32     = (32'(chunk) << 5) | 32'(lowest_set(chunk_bits));
  assign scan_sum   = scan32[SUM_AW-1:0];
  assign found32    = (32'(sum_addr) << 5) | 32'(lowest_set(sm_rdata));
  assign found_word = found32[WORD_AW-1:0];

  // Reserve and allocate set the bit; release clears it.
  assign set_op   = (act != ACT_RELEASE);
  assign bit_mask = 32'd1 << bit_idx;
  assign changed  = (word_q[bit_idx] != set_op);
  assign new_word = set_op ? (word_q | bit_mask) : (word_q & ~bit_mask);
  assign word32   = 32'(word_addr);
  assign page32   = (word32 << 5) | 32'(bit_idx);
  assign clr32    = 32'(clr_idx);

  always_comb begin
    new_sum = sum_q;
    new_sum[word32[4:0]] = (new_word != '1);
  end

  always_comb begin
    cnt_next = cnt;
    if (changed) begin
      if (!set_op) begin
        cnt_next = cnt + 1'b1;
      end else if (cnt != '0) begin
        cnt_next = cnt - 1'b1;
      end
    end
  end

  // Memory control: the clearing pass writes every word, the update state
  // writes back the modified bitmap and summary words.
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = word_addr;
    bm_wdata = new_word;
    sm_we    = 1'b0;
    sm_waddr = sum_addr;
    sm_wdata = new_sum;
    if (state == S_CLEAR) begin
      bm_we    = 1'b1;
      bm_waddr = clr_idx;
      bm_wdata = '1;
      sm_we    = (clr32 < 32'(NUM_SUM));
      sm_waddr = clr32[SUM_AW-1:0];
      sm_wdata = '0;
    end else if (state == S_UPD && slot_free) begin
      bm_we = 1'b1;
      sm_we = 1'b1;
    end
  end

  assign bm_raddr = (state == S_IDLE) ? req_word : found_word;
  assign sm_raddr = (state == S_IDLE) ? req_sum : scan_sum;

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    bm_rdata <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      sm_mem[sm_waddr] <= sm_wdata;
    end
    sm_rdata <= sm_mem[sm_raddr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      flags     <= '0;
      cnt       <= '0;
      chunk     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == WORD_AW'(NUM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            act       <= req.action;
            word_addr <= req_word;
            sum_addr  <= req_sum;
            bit_idx   <= req_page32[4:0];
            chunk     <= '0;
            unique case (req.action) inside
              ACT_RELEASE, ACT_RESERVE: begin
                state <= req_in_range ? S_LOAD : S_DONE;
              end
              ACT_ALLOCATE: begin
                state <= S_SCAN;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LOAD: begin
          word_q <= bm_rdata;
          sum_q  <= sm_rdata;
          state  <= S_UPD;
        end
        S_SCAN: begin
          if (chunk_bits != '0) begin
            sum_addr <= scan_sum;
            state    <= S_SUMRD;
          end else if (chunk == CHUNK_AW'(NUM_CHUNK - 1)) begin
            state <= S_DONE;
          end else begin
            chunk <= chunk + 1'b1;
          end
        end
        S_SUMRD: begin
          sum_q     <= sm_rdata;
          word_addr <= found_word;
          state     <= S_WRD;
        end
        S_WRD: begin
          word_q  <= bm_rdata;
          bit_idx <= lowest_set(~bm_rdata);
          state   <= S_UPD;
        end
        S_UPD: begin
          if (slot_free) begin
            flags[sum_addr] <= (new_sum != '0);
            cnt             <= cnt_next;
            out_valid       <= 1'b1;
            out_granted     <= 1'b1;
            out_address     <= (act == ACT_ALLOCATE) ? (page32 << PAGE_SHIFT) : '0;
            out_count       <= COUNT_W'(cnt_next);
            state           <= S_IDLE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            out_granted <= 1'b0;
            out_address <= '0;
            out_count   <= COUNT_W'(cnt);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.granted       = out_granted;
  assign rsp.alloc_address = out_address;
  assign rsp.free_count    = out_count;

  // A set flag must point at a summary word that really has a free word.
  a_summary_consistent: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUMRD) |-> (sm_rdata != '0))
    else $error("summary word selected by a set flag is empty");

  // The page chosen by an allocate must be free in the word read back.
  a_alloc_bit_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && act == ACT_ALLOCATE) |-> !word_q[bit_idx])
    else $error("allocate picked a page that is already used");

  // The free count can never exceed the number of pages.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= 32'(NUM_PAGES))
    else $error("free count exceeds the number of pages");

endmodule

`default_nettype wire

FILE: dv/bitmap_page_allocator_tb.sv
// Self-checking testbench of the bitmap page allocator: directed rows, then random traffic.
module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PAGES    = 65536;
  localparam int PAGE_SHIFT   = 12;
  localparam int BITMAP_WORDS = NUM_PAGES / 32;
  localparam int N_DIRECTED   = 24;
  localparam int N_RANDOM     = 680;

  // The receiver holds ready low for this many cycles once, so that the output
  // register stays full and the block has to push back on its request side.
  localparam int LONG_HOLD   = 200;
  localparam int HOLD_AFTER  = 150;

  // The longest correct stretch without any transaction is the clearing pass
  // after reset, which writes every bitmap word (2048 here). The long receiver
  // hold, the sender's gaps and an allocate are far shorter. The limit is that
  // worst case taken about three times over.
  localparam int WATCHDOG_LIMIT = 3 * BITMAP_WORDS;

  // The tail leaves room for any response that should not exist to show up.
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic   granted;
    addr_t  alloc_address;
    count_t free_count;
  } bpa_result_t;

  // One row of the directed stimulus. Where typed is set, the expected response
  // is written in the row; otherwise it comes from the predictor.
  typedef struct packed {
    action_t act;
    addr_t   addr;
    logic    typed;
    logic    granted;
    addr_t   alloc_address;
    count_t  free_count;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // Right after reset every page is used and the count is zero.
    '{ACT_ALLOCATE, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 17'd0},
    '{ACT_NOP,      32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 17'd0},
    // Free page 0, then free it again: the count moves only once.
    '{ACT_RELEASE,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 17'd1},
    '{ACT_RELEASE,  32'h0000_0FFF, 1'b1, 1'b1, 32'h0000_0000, 17'd1},
    // Pages past the end of memory are refused and change nothing.
    '{ACT_RELEASE,  32'h1000_0000, 1'b1, 1'b0, 32'h0000_0000, 17'd1},
    '{ACT_RESERVE,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 17'd1},
    // Allocate takes page 0, after which nothing is left.
    '{ACT_ALLOCATE, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'h0000_0000, 17'd0},
    '{ACT_ALLOCATE, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 17'd0},
    // The highest page, reached through an address with every offset bit set.
    '{ACT_RELEASE,  32'h0FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 17'd1},
    '{ACT_ALLOCATE, 32'h0000_0000, 1'b1, 1'b1, 32'h0FFF_F000, 17'd0},
    // Reserve of a free page, reserve of a used page, then first fit picks 3.
    '{ACT_RELEASE,  32'h0000_5ABC, 1'b1, 1'b1, 32'h0000_0000, 17'd1},
    '{ACT_RELEASE,  32'h0000_3000, 1'b1, 1'b1, 32'h0000_0000, 17'd2},
    '{ACT_RESERVE,  32'h0000_5000, 1'b1, 1'b1, 32'h0000_0000, 17'd1},
    '{ACT_RESERVE,  32'h0000_5FFF, 1'b1, 1'b1, 32'h0000_0000, 17'd1},
    '{ACT_ALLOCATE, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_3000, 17'd0},
    // Free pages in other bitmap words and summary groups; scan across them.
    '{ACT_RELEASE,  32'h0002_0000, 1'b0, 1'b0, 32'h0000_0000, 17'd0},
    '{ACT_RELEASE,  32'h0080_0000, 1'b0, 1'b0, 32'h0000_0000, 17'd0},
    '{ACT_RELEASE,  32'h0FFE_0000, 1'b0, 1'b0, 32'h0000_0000, 17'd0},
    '{ACT_ALLOCATE, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 17'd0},
    '{ACT_ALLOCATE, 32'hFFFF_F000, 1'b0, 1'b0, 32'h0000_0000, 17'd0},
    '{ACT_NOP,      32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000, 17'd0},
    '{ACT_ALLOCATE, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 17'd0},
    '{ACT_ALLOCATE, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 17'd0},
    '{ACT_RESERVE,  32'h0FFF_F000, 1'b0, 1'b0, 32'h0000_0000, 17'd0}
  };

  logic clk;
  logic rst;

  bpa_req_if req_ch();
  bpa_rsp_if rsp_ch();

  bitmap_page_allocator #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the allocator state, kept in step with accepted requests.
  logic [31:0] page_used [BITMAP_WORDS];
  int          shadow_free;

  // Responses still owed by the block, oldest first.
  bpa_result_t pending_results [$];
  bpa_result_t expected_now;

  int          mismatches;
  int          responses_seen;
  int          idle_cycles;
  int          burst_left;
  int unsigned action_counts [4];
  int unsigned allocs_granted;
  int unsigned allocs_refused;
  int          peak_free;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one request to the shadow bitmap and returns the response that the
  // block must give for it. Page numbers of NUM_PAGES or more and the spare action
  // code leave the state alone; allocate takes the lowest free page.
  function automatic bpa_result_t predict_response(input action_t act, input addr_t addr);
    bpa_result_t res;
    int unsigned page;
    int          w;
    int          b;
    logic [63:0] wide_addr;
    res  = '0;
    page = addr >> PAGE_SHIFT;
    unique case (act) inside
      ACT_RELEASE, ACT_RESERVE: begin
        if (page < NUM_PAGES) begin
          if (act == ACT_RELEASE && page_used[page / 32][page % 32]) begin
            page_used[page / 32][page % 32] = 1'b0;
            shadow_free++;
          end else if (act == ACT_RESERVE && !page_used[page / 32][page % 32]) begin
            page_used[page / 32][page % 32] = 1'b1;
            if (shadow_free > 0) shadow_free--;
          end
          res.granted = 1'b1;
        end
      end
      ACT_ALLOCATE: begin
        w = 0;
        while (w < BITMAP_WORDS && page_used[w] == 32'hFFFF_FFFF) w++;
        if (w < BITMAP_WORDS) begin
          b = 0;
          while (page_used[w][b]) b++;
          page_used[w][b] = 1'b1;
          if (shadow_free > 0) shadow_free--;
          // Only the low 32 bits of the byte address are returned.
          wide_addr         = 64'(w * 32 + b) << PAGE_SHIFT;
          res.granted       = 1'b1;
          res.alloc_address = wide_addr[ADDR_W-1:0];
          allocs_granted++;
        end else begin
          allocs_refused++;
        end
      end
      default: begin
      end
    endcase
    res.free_count = COUNT_W'(shadow_free);
    if (shadow_free > peak_free) peak_free = shadow_free;
    return res;
  endfunction

  // Holds one request transaction on the channel until the block takes it,
  // then records the response that it owes.
  task automatic offer_request(input action_t act, input addr_t addr, input logic typed,
                               input bpa_result_t typed_result);
    bpa_result_t predicted;
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.page_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_response(act, addr);
    action_counts[act]++;
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // The sender works in bursts; between bursts it usually drops valid for a random gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stimulus: reset, the directed rows, then random segments whose mix of
  // releases and allocates swings between filling and draining the free pool.
  initial begin
    bpa_result_t typed_result;
    int          sent;
    int          seg_len;
    int          release_bias;
    int          pick;
    int unsigned page;
    action_t     act;
    addr_t       addr;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.action       <= ACT_NOP;
    req_ch.page_address <= '0;
    foreach (page_used[i]) page_used[i] = 32'hFFFF_FFFF;
    shadow_free    = 0;
    peak_free      = 0;
    mismatches     = 0;
    burst_left     = 0;
    allocs_granted = 0;
    allocs_refused = 0;
    foreach (action_counts[i]) action_counts[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_result = '{DIRECTED_ROWS[i].granted, DIRECTED_ROWS[i].alloc_address,
                       DIRECTED_ROWS[i].free_count};
      offer_request(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].typed,
                    typed_result);
      pace_sender();
    end

    sent = 0;
    while (sent < N_RANDOM) begin
      seg_len      = $urandom_range(10, 60);
      release_bias = $urandom_range(20, 70);
      repeat (seg_len) begin
        pick = $urandom_range(0, 99);
        if (pick < release_bias) act = ACT_RELEASE;
        else if (pick < release_bias + 10) act = ACT_RESERVE;
        else if (pick < 95) act = ACT_ALLOCATE;
        else act = ACT_NOP;
        // Most traffic stays in the low words where allocates land; some goes to
        // the top of memory, anywhere in range, or to a fully random address,
        // which is usually past the last page.
        pick = $urandom_range(0, 99);
        if (pick < 70) page = $urandom_range(0, 127);
        else if (pick < 80) page = $urandom_range(NUM_PAGES - 40, NUM_PAGES - 1);
        else page = $urandom_range(0, NUM_PAGES - 1);
        addr = (page << PAGE_SHIFT) | $urandom_range(0, (1 << PAGE_SHIFT) - 1);
        if (pick >= 90) addr = $urandom;
        offer_request(act, addr, 1'b0, '0);
        pace_sender();
        sent++;
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d releases, %0d reserves, %0d allocates, %0d spare codes.",
             N_DIRECTED + sent, action_counts[ACT_RELEASE], action_counts[ACT_RESERVE],
             action_counts[ACT_ALLOCATE], action_counts[ACT_NOP]);
    $display("Allocates granted %0d, refused %0d; peak free pages %0d; %0d mismatches.",
             allocs_granted, allocs_refused, peak_free, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // The receiver cycles through segments of steady, random and periodic ready,
  // and once, some way into the run, refuses everything for a long stretch.
  initial begin
    int  seg_len;
    int  mode;
    int  phase;
    bit  held;
    held  = 1'b0;
    phase = 0;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && responses_seen >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(1, 40);
      repeat (seg_len) begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          default: rsp_ch.ready <= (phase % 4) != 0;
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  // Every response transaction is compared field by field with the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      responses_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: response with nothing expected: granted %0b address %h count %0d",
                 $time, rsp_ch.granted, rsp_ch.alloc_address, rsp_ch.free_count);
      end else begin
        expected_now = pending_results.pop_front();
        if (rsp_ch.granted !== expected_now.granted) begin
          mismatches++;
          $display("%0t: granted expected %0b actual %0b", $time, expected_now.granted,
                   rsp_ch.granted);
        end
        if (rsp_ch.alloc_address !== expected_now.alloc_address) begin
          mismatches++;
          $display("%0t: alloc_address expected %h actual %h", $time,
                   expected_now.alloc_address, rsp_ch.alloc_address);
        end
        if (rsp_ch.free_count !== expected_now.free_count) begin
          mismatches++;
          $display("%0t: free_count expected %0d actual %0d", $time,
                   expected_now.free_count, rsp_ch.free_count);
        end
      end
    end
  end

  // Ends the run when neither channel has moved a transaction for too long.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule

FILE: filelist.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_req_if.sv
rtl/core/bpa_rsp_if.sv
rtl/core/bitmap_page_allocator.sv
dv/bitmap_page_allocator_tb.sv
